### hw/rtl/cbe_pkg.sv
// cbe_pkg: constants, types and arithmetic helpers for the bezier easing block
// no dependencies
package cbe_pkg;

  localparam int TABLE_DIV  = 32;
  localparam int MAX_ITER   = 32;
  localparam int Q_W        = 19;
  localparam int ONE_Q16    = 65536;
  localparam int EPS_Q16    = 66;
  localparam int Q_MAX      = 262143;
  localparam int Q_MIN      = -262144;
  localparam int ADDR_W     = $clog2(TABLE_DIV + 1);
  localparam int ITER_W     = $clog2(MAX_ITER + 1);
  localparam int QQ_W       = Q_W + $clog2(TABLE_DIV) + 1;
  localparam int TERM_W     = 32;
  localparam int MA_W       = 28;
  localparam int MB_W       = 22;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_CFG    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_C1X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C1Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C2X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C2Y = 3'd3;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  // multiplier step codes
  typedef enum logic [2:0] {
    MS_TT, MS_INV2, MS_INV2T, MS_A, MS_INVTT, MS_B, MS_C, MS_FRAC
  } mstep_t;

  typedef enum logic [1:0] {RS_QUERY, RS_RAM, RS_INTERP} rsel_t;
  typedef enum logic [1:0] {WS_ZERO, WS_ONE, WS_BEZ} wsel_t;

  typedef struct packed {
    logic   ld_query;
    logic   chk;
    logic   smp_init;
    logic   mul_en;
    mstep_t mstep;
    logic   use_y;
    logic   t_upd;
    logic   wr_en;
    wsel_t  wr_sel;
    addr_t  addr;
    logic   rd_next;
    logic   ld_y0;
    logic   res_ld;
    rsel_t  res_sel;
    logic   out_ld;
  } cmd_t;

  typedef struct packed {
    logic ident;
    logic err_small;
    logic clamp;
  } sts_t;

  function automatic q_t sat19(input term_t v);
    q_t r;
    if (v > term_t'(Q_MAX)) r = q_t'(Q_MAX);
    else if (v < term_t'(Q_MIN)) r = q_t'(Q_MIN);
    else r = v[Q_W-1:0];
    return r;
  endfunction

  // rescale by 2^-16, round half away from zero
  function automatic term_t qmul(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    term_t             r;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    rnd = (mag + PROD_W'(32768)) >> 16;
    r = term_t'(rnd[TERM_W-1:0]);
    return p[PROD_W-1] ? -r : r;
  endfunction

  // x position of a table sample
  function automatic term_t sample_x(input addr_t i);
    int v;
    v = (int'(i) * ONE_Q16 + TABLE_DIV / 2) / TABLE_DIV;
    return term_t'(v);
  endfunction

endpackage

### hw/rtl/cbe_if.sv
// cbe_if: valid/ready channel interfaces for query and result words
// depends on cbe_pkg
interface cbe_in_if;
  logic        valid;
  logic        ready;
  cbe_pkg::q_t query_x;
  modport source(output valid, output query_x, input ready);
  modport sink(input valid, input query_x, output ready);
endinterface

interface cbe_out_if;
  logic        valid;
  logic        ready;
  cbe_pkg::q_t eased_y;
  modport source(output valid, output eased_y, input ready);
  modport sink(input valid, input eased_y, output ready);
endinterface

### hw/rtl/cubic_bezier_easing_table_top.sv
// cubic bezier easing top: the serial state machine accepts a query word only when idle and
// takes no new one until the result has passed its single result register into the output
// register (identity mode bypasses the table, a clamped index skips the interpolation)
// the first query after reset or a config write, unless in identity mode, first builds the
// 33 entry table: ends written directly, inner samples solved on one shared multiplier
// synchronous active low reset clears control, presets config; table rebuilt before use
module cubic_bezier_easing_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  cbe_in_if.sink                        in_ch,
  cbe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  cbe_pkg::q_t                   cfg_data
);
  cbe_pkg::cmd_t cmd;
  cbe_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;
  cbe_pkg::q_t   eased;

  cbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_x     (in_ch.query_x),
    .cmd      (cmd),
    .sts      (sts),
    .eased    (eased)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.eased_y = eased;
endmodule

### hw/rtl/cbe_ram.sv
// cbe_ram: generic single write, single read RAM with registered read
// no dependencies
module cbe_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### hw/rtl/cbe_dp.sv
// cbe_dp: datapath, control point registers, shared multiplier, sample table
// depends on cbe_pkg and cbe_ram
module cbe_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  cbe_pkg::q_t                        cfg_data,
  input  cbe_pkg::q_t                        in_x,
  input  cbe_pkg::cmd_t                      cmd,
  output cbe_pkg::sts_t                      sts,
  output cbe_pkg::q_t                        eased
);
  cbe_pkg::q_t   c1x_r, c1y_r, c2x_r, c2y_r;
  cbe_pkg::q_t   qx_r, t_r, y0_r, res_r, eased_r;
  cbe_pkg::term_t tt_r, p_r, a_r, b_r, cc_r;
  logic          ident_r;

  logic signed [cbe_pkg::Q_W:0]   inv;
  logic signed [cbe_pkg::Q_W+1:0] c1_3, c2_3, c1_sel, c2_sel;
  logic signed [cbe_pkg::MA_W-1:0] ma;
  logic signed [cbe_pkg::MB_W-1:0] mb;
  logic signed [cbe_pkg::PROD_W-1:0] prod;
  cbe_pkg::term_t prod_q, bez, err, half, d1, d2;
  logic          ident_c;
  logic signed [cbe_pkg::QQ_W-1:0] q;
  logic          q_lo, q_hi;
  logic signed [16:0] frac;
  cbe_pkg::addr_t base, raddr, wr_addr;
  cbe_pkg::q_t   wdata, rdata;
  logic signed [cbe_pkg::Q_W:0] diff;

  // times three control values
  always_comb begin
    c1_sel = cmd.use_y ? (cbe_pkg::Q_W+2)'(c1y_r) : (cbe_pkg::Q_W+2)'(c1x_r);
    c2_sel = cmd.use_y ? (cbe_pkg::Q_W+2)'(c2y_r) : (cbe_pkg::Q_W+2)'(c2x_r);
    c1_3 = (c1_sel <<< 1) + c1_sel;
    c2_3 = (c2_sel <<< 1) + c2_sel;
  end

  assign inv = (cbe_pkg::Q_W+1)'(cbe_pkg::ONE_Q16) - (cbe_pkg::Q_W+1)'(t_r);

  // query index clamp and fraction
  always_comb begin
    q    = cbe_pkg::QQ_W'(qx_r) * cbe_pkg::QQ_W'(cbe_pkg::TABLE_DIV);
    q_lo = q <= cbe_pkg::QQ_W'(-cbe_pkg::ONE_Q16);
    q_hi = q >= cbe_pkg::QQ_W'(cbe_pkg::TABLE_DIV * cbe_pkg::ONE_Q16);
    if (q_hi) base = cbe_pkg::addr_t'(cbe_pkg::TABLE_DIV);
    else if (q[cbe_pkg::QQ_W-1]) base = '0;
    else base = q[16 +: cbe_pkg::ADDR_W];
    frac  = q[cbe_pkg::QQ_W-1] ? q[16:0] : {1'b0, q[15:0]};
    raddr = cmd.rd_next ? cbe_pkg::addr_t'(base + 1'b1) : base;
  end

  assign diff = (cbe_pkg::Q_W+1)'(rdata) - (cbe_pkg::Q_W+1)'(y0_r);

  // shared multiplier operand select
  always_comb begin
    case (cmd.mstep)
      cbe_pkg::MS_TT: begin
        ma = cbe_pkg::MA_W'(t_r);
        mb = cbe_pkg::MB_W'(t_r);
      end
      cbe_pkg::MS_INV2: begin
        ma = cbe_pkg::MA_W'(inv);
        mb = cbe_pkg::MB_W'(inv);
      end
      cbe_pkg::MS_INV2T: begin
        ma = p_r[cbe_pkg::MA_W-1:0];
        mb = cbe_pkg::MB_W'(t_r);
      end
      cbe_pkg::MS_A: begin
        ma = p_r[cbe_pkg::MA_W-1:0];
        mb = cbe_pkg::MB_W'(c1_3);
      end
      cbe_pkg::MS_INVTT: begin
        ma = cbe_pkg::MA_W'(inv);
        mb = tt_r[cbe_pkg::MB_W-1:0];
      end
      cbe_pkg::MS_B: begin
        ma = b_r[cbe_pkg::MA_W-1:0];
        mb = cbe_pkg::MB_W'(c2_3);
      end
      cbe_pkg::MS_C: begin
        ma = tt_r[cbe_pkg::MA_W-1:0];
        mb = cbe_pkg::MB_W'(t_r);
      end
      cbe_pkg::MS_FRAC: begin
        ma = cbe_pkg::MA_W'(diff);
        mb = cbe_pkg::MB_W'(frac);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod   = cbe_pkg::PROD_W'(ma) * cbe_pkg::PROD_W'(mb);
    prod_q = cbe_pkg::qmul(prod);
  end

  // solver error, damped step and identity check
  always_comb begin
    bez  = a_r + b_r + cc_r;
    err  = bez - cbe_pkg::sample_x(cmd.addr);
    half = (err + cbe_pkg::term_t'(err[cbe_pkg::TERM_W-1])) >>> 1;
    d1   = cbe_pkg::term_t'(c1x_r) - cbe_pkg::term_t'(c1y_r);
    d2   = cbe_pkg::term_t'(c2x_r) - cbe_pkg::term_t'(c2y_r);
    ident_c = (d1 < cbe_pkg::EPS_Q16) && (d1 > -cbe_pkg::EPS_Q16) &&
              (d2 < cbe_pkg::EPS_Q16) && (d2 > -cbe_pkg::EPS_Q16);
  end

  always_comb begin
    case (cmd.wr_sel)
      cbe_pkg::WS_ZERO: wdata = '0;
      cbe_pkg::WS_ONE:  wdata = cbe_pkg::q_t'(cbe_pkg::ONE_Q16);
      default:          wdata = cbe_pkg::sat19(bez);
    endcase
  end

  assign wr_addr = cmd.addr;

  cbe_ram #(
    .WIDTH(cbe_pkg::Q_W),
    .DEPTH(cbe_pkg::TABLE_DIV + 1)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(wr_addr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // configuration and identity flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1x_r   <= '0;
      c1y_r   <= '0;
      c2x_r   <= cbe_pkg::q_t'(cbe_pkg::ONE_Q16);
      c2y_r   <= cbe_pkg::q_t'(cbe_pkg::ONE_Q16);
      ident_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cbe_pkg::CFG_C1X: c1x_r <= cfg_data;
          cbe_pkg::CFG_C1Y: c1y_r <= cfg_data;
          cbe_pkg::CFG_C2X: c2x_r <= cfg_data;
          cbe_pkg::CFG_C2Y: c2y_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.chk) begin
        ident_r <= ident_c;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_query) qx_r <= in_x;
    if (cmd.smp_init) t_r <= cbe_pkg::q_t'(cbe_pkg::sample_x(cmd.addr));
    else if (cmd.t_upd) t_r <= cbe_pkg::sat19(cbe_pkg::term_t'(t_r) - half);
    if (cmd.mul_en) begin
      case (cmd.mstep)
        cbe_pkg::MS_TT:    tt_r <= prod_q;
        cbe_pkg::MS_A:     a_r  <= prod_q;
        cbe_pkg::MS_INVTT,
        cbe_pkg::MS_B:     b_r  <= prod_q;
        cbe_pkg::MS_C:     cc_r <= prod_q;
        default:           p_r  <= prod_q;
      endcase
    end
    if (cmd.ld_y0) y0_r <= rdata;
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        cbe_pkg::RS_QUERY: res_r <= qx_r;
        cbe_pkg::RS_RAM:   res_r <= rdata;
        default:           res_r <= cbe_pkg::sat19(cbe_pkg::term_t'(y0_r) + p_r);
      endcase
    end
    if (cmd.out_ld) eased_r <= res_r;
  end

  assign sts.ident     = ident_r;
  assign sts.err_small = (err < cbe_pkg::EPS_Q16) && (err > -cbe_pkg::EPS_Q16);
  assign sts.clamp     = q_lo || q_hi;
  assign eased         = eased_r;
endmodule

### hw/rtl/cbe_ctrl.sv
// cbe_ctrl: controller state machine for table build and query sequencing
// depends on cbe_pkg
module cbe_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  cbe_pkg::sts_t                 sts,
  output cbe_pkg::cmd_t                 cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_ROUTE, S_CHECK, S_END_LO, S_END_HI, S_INIT, S_MUL, S_EVAL,
    S_RD1, S_INTERP, S_SUM, S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       ready_r, ready_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cbe_pkg::addr_t             addr_r, addr_nxt;
  logic [cbe_pkg::ITER_W-1:0] iter_r, iter_nxt;
  cbe_pkg::mstep_t            step_r, step_nxt;
  logic                       use_y_r, use_y_nxt;
  logic                       cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index < cbe_pkg::CFG_IDX_W'(cbe_pkg::NUM_CFG));

  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    addr_nxt  = addr_r;
    iter_nxt  = iter_r;
    step_nxt  = step_r;
    use_y_nxt = use_y_r;
    cmd       = '0;
    cmd.addr  = addr_r;
    cmd.use_y = use_y_r;
    cmd.mstep = step_r;
    cmd.wr_sel = cbe_pkg::WS_BEZ;
    cmd.res_sel = cbe_pkg::RS_QUERY;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_query = 1'b1;
          state_nxt = ready_r ? S_ROUTE : S_CHECK;
        end
      end
      S_ROUTE: begin
        // first table read issued here
        if (sts.ident) begin
          cmd.res_ld = 1'b1;
          cmd.res_sel = cbe_pkg::RS_QUERY;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD1;
        end
      end
      S_CHECK: begin
        cmd.chk = 1'b1;
        state_nxt = S_END_LO;
      end
      S_END_LO: begin
        if (sts.ident) begin
          ready_nxt = 1'b1;
          state_nxt = S_ROUTE;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.addr   = '0;
          cmd.wr_sel = cbe_pkg::WS_ZERO;
          state_nxt  = S_END_HI;
        end
      end
      S_END_HI: begin
        cmd.wr_en  = 1'b1;
        cmd.addr   = cbe_pkg::addr_t'(cbe_pkg::TABLE_DIV);
        cmd.wr_sel = cbe_pkg::WS_ONE;
        addr_nxt   = cbe_pkg::addr_t'(1);
        state_nxt  = S_INIT;
      end
      S_INIT: begin
        cmd.smp_init = 1'b1;
        iter_nxt  = '0;
        step_nxt  = cbe_pkg::MS_TT;
        use_y_nxt = 1'b0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (step_r == cbe_pkg::MS_C) begin
          state_nxt = S_EVAL;
        end else begin
          step_nxt = cbe_pkg::mstep_t'(step_r + 1'b1);
        end
      end
      S_EVAL: begin
        step_nxt = cbe_pkg::MS_TT;
        if (use_y_r) begin
          cmd.wr_en = 1'b1;
          if (addr_r == cbe_pkg::addr_t'(cbe_pkg::TABLE_DIV - 1)) begin
            ready_nxt = 1'b1;
            state_nxt = S_ROUTE;
          end else begin
            addr_nxt  = cbe_pkg::addr_t'(addr_r + 1'b1);
            state_nxt = S_INIT;
          end
        end else if (sts.err_small) begin
          use_y_nxt = 1'b1;
          state_nxt = S_MUL;
        end else begin
          cmd.t_upd = 1'b1;
          if (iter_r == cbe_pkg::ITER_W'(cbe_pkg::MAX_ITER - 1)) begin
            use_y_nxt = 1'b1;
          end else begin
            iter_nxt = cbe_pkg::ITER_W'(iter_r + 1'b1);
          end
          state_nxt = S_MUL;
        end
      end
      S_RD1: begin
        cmd.rd_next = 1'b1;
        cmd.ld_y0   = 1'b1;
        if (sts.clamp) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = cbe_pkg::RS_RAM;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_INTERP;
        end
      end
      S_INTERP: begin
        cmd.rd_next = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mstep   = cbe_pkg::MS_FRAC;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = cbe_pkg::RS_INTERP;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_hit) begin
      ready_nxt = 1'b0;
    end
    out_valid_nxt = cmd.out_ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      iter_r      <= '0;
      step_r      <= cbe_pkg::MS_TT;
      use_y_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      addr_r      <= addr_nxt;
      iter_r      <= iter_nxt;
      step_r      <= step_nxt;
      use_y_r     <= use_y_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !in_ready)
    else $error("table written while taking words");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !ready_r)
    else $error("table still marked ready after config write");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (iter_r < cbe_pkg::ITER_W'(cbe_pkg::MAX_ITER)))
    else $error("solver iteration count overrun");
endmodule
